@@ src/decimal_text_number_parser_macros.svh @@
// Assertion macros shared by the decimal text number parser RTL.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef DECIMAL_TEXT_NUMBER_PARSER_MACROS_SVH
`define DECIMAL_TEXT_NUMBER_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTNP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTNP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/dtnp_pkg.sv @@
// Shared types and constants of the decimal text number parser.
// No dependencies; every other file of the block but the macro header imports this package.
package dtnp_pkg;

   localparam int CHAR_W             = 8;
   localparam int TYPE_W             = 3;
   localparam int STATUS_W           = 3;
   localparam int ACC_W              = 34;
   localparam int VAL_W              = 35;
   localparam int FRAC_W             = 4;
   localparam int MAX_DIGITS_DEFAULT = 10;
   localparam int QUEUE_DEPTH        = 2;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_IDX_W          = CSR_ADDR_W - 2;
   localparam int CSR_DATA_W         = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_TYPE = '0;

   // Magnitude limits of the integer target types.
   localparam logic [ACC_W-1:0] U8_MAX  = 34'd255;
   localparam logic [ACC_W-1:0] U16_MAX = 34'd65535;
   localparam logic [ACC_W-1:0] U32_MAX = 34'd4294967295;
   localparam logic [ACC_W-1:0] I8_POS  = 34'd127;
   localparam logic [ACC_W-1:0] I8_NEG  = 34'd128;
   localparam logic [ACC_W-1:0] I16_POS = 34'd32767;
   localparam logic [ACC_W-1:0] I16_NEG = 34'd32768;
   localparam logic [ACC_W-1:0] I32_POS = 34'd2147483647;
   localparam logic [ACC_W-1:0] I32_NEG = 34'd2147483648;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK, ST_BAD_CHAR, ST_TOO_LONG, ST_POINT_INT,
      ST_MINUS_UNS, ST_HEX, ST_BIN, ST_RANGE
   } status_type;

   typedef enum logic [TYPE_W-1:0] {
      VT_BOOL, VT_U8, VT_U16, VT_U32, VT_I8, VT_I16, VT_I32, VT_REAL
   } vtype_type;

   localparam vtype_type VALUE_TYPE_RESET = VT_U8;

   typedef enum logic [2:0] {
      CC_SKIP, CC_ZERO, CC_DIGIT, CC_HEX_X, CC_BIN_B, CC_POINT, CC_MINUS, CC_OTHER
   } char_class_type;

   // One classified character as it travels from the front to the back.
   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      logic           bool_false;
      logic           bool_true;
      logic           last;
      vtype_type      vtype;
   } entry_type;

endpackage

@@ src/dtnp_req_if.sv @@
// Input character channel of the decimal text number parser.
// Depends on dtnp_pkg for the field widths.
interface dtnp_req_if import dtnp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              line_end;

   modport source (output valid, output char_code, output line_end, input ready);
   modport sink (input valid, input char_code, input line_end, output ready);
endinterface

@@ src/dtnp_rsp_if.sv @@
// Result channel of the decimal text number parser.
// Depends on dtnp_pkg for the field widths.
interface dtnp_rsp_if import dtnp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic signed [VAL_W-1:0] number_value;
   logic [FRAC_W-1:0]       fraction_digits;
   logic                    bool_result;

   modport source (output valid, output status, output number_value,
                   output fraction_digits, output bool_result, input ready);
   modport sink (input valid, input status, input number_value,
                 input fraction_digits, input bool_result, output ready);
endinterface

@@ src/dtnp_front.sv @@
// Front end: accepts characters, classifies them and queues them for the back end.
// Depends on dtnp_pkg, dtnp_req_if and the assertion macro header.
`include "decimal_text_number_parser_macros.svh"

module dtnp_front import dtnp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dtnp_req_if.sink   req,
   input  vtype_type  value_type,
   output entry_type  head,
   output logic       head_valid,
   input  logic       pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_APOS  = 8'h27;
   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_B  = 8'h42;
   localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
   localparam logic [CHAR_W-1:0] CH_UP_T  = 8'h54;
   localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
   localparam logic [CHAR_W-1:0] CH_LO_T  = 8'h74;
   localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

   entry_type         queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   entry_type         new_entry;
   logic              push;

   always_comb begin
      new_entry            = '0;
      new_entry.digit      = req.char_code[3:0];
      new_entry.last       = req.line_end;
      new_entry.vtype      = value_type;
      new_entry.bool_false = (req.char_code == CH_ZERO) || (req.char_code == CH_LO_F)
                             || (req.char_code == CH_UP_F);
      new_entry.bool_true  = (req.char_code == CH_ONE) || (req.char_code == CH_LO_T)
                             || (req.char_code == CH_UP_T);
      case (req.char_code)
         CH_SPACE, CH_APOS:  new_entry.cls = CC_SKIP;
         CH_ZERO:            new_entry.cls = CC_ZERO;
         CH_LO_X:            new_entry.cls = CC_HEX_X;
         CH_UP_B:            new_entry.cls = CC_BIN_B;
         CH_POINT, CH_COMMA: new_entry.cls = CC_POINT;
         CH_MINUS:           new_entry.cls = CC_MINUS;
         default: begin
            if ((req.char_code >= CH_ONE) && (req.char_code <= CH_NINE)) begin
               new_entry.cls = CC_DIGIT;
            end else begin
               new_entry.cls = CC_OTHER;
            end
         end
      endcase
   end

   assign req.ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req.valid && req.ready;
   assign head       = queue_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

   `DTNP_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

@@ src/dtnp_back.sv @@
// Back end: applies queued characters to the line state and forms the line result.
// Depends on dtnp_pkg, dtnp_rsp_if and the assertion macro header.
`include "decimal_text_number_parser_macros.svh"

module dtnp_back import dtnp_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       head_valid,
   output logic       pop,
   dtnp_rsp_if.source rsp
);

   localparam int DC_W = $clog2(MAX_DIGITS + 1);
   localparam logic [DC_W-1:0] MAX_DC = DC_W'(MAX_DIGITS);

   // Line state as it stands after the last character of a line.
   typedef struct packed {
      vtype_type        vtype;
      status_type       err;
      logic [ACC_W-1:0] acc;
      logic             neg;
      logic             point;
      logic [DC_W-1:0]  dc;
      logic [DC_W-1:0]  unit;
      logic             blatch;
   } snap_type;

   status_type       err_ff, err_in, upd_err;
   logic [DC_W-1:0]  dc_ff, dc_in, upd_dc;
   logic [ACC_W-1:0] acc_ff, acc_in, upd_acc;
   logic             neg_ff, neg_in, upd_neg;
   logic             point_ff, point_in, upd_point;
   logic             lz_ff, lz_in, upd_lz;
   logic [DC_W-1:0]  unit_ff, unit_in, upd_unit;
   logic             first_ff, first_in, upd_first;
   logic             blatch_ff, blatch_in, upd_blatch;

   logic             fin_valid_ff, fin_valid_in;
   snap_type         fin_ff, fin_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic             bres_ff, bres_in;

   logic             out_free, fin_free, fin_adv, line_done;
   logic             is_real, is_uns, range_ok;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign fin_adv   = fin_valid_ff && out_free;
   assign fin_free  = !fin_valid_ff || out_free;
   assign pop       = head_valid && (!head.last || fin_free);
   assign line_done = pop && head.last;

   assign is_real = (head.vtype == VT_REAL);
   assign is_uns  = (head.vtype == VT_U8) || (head.vtype == VT_U16) || (head.vtype == VT_U32);

   // Effect of the head character on the line state.
   always_comb begin
      upd_err    = err_ff;
      upd_dc     = dc_ff;
      upd_acc    = acc_ff;
      upd_neg    = neg_ff;
      upd_point  = point_ff;
      upd_lz     = lz_ff;
      upd_unit   = unit_ff;
      upd_first  = 1'b0;
      upd_blatch = blatch_ff;
      if (head.vtype == VT_BOOL) begin
         upd_first = first_ff;
         if (first_ff) begin
            upd_first = 1'b0;
            if (head.bool_false) begin
               upd_blatch = 1'b0;
            end else if (head.bool_true) begin
               upd_blatch = 1'b1;
            end else begin
               upd_err = ST_BAD_CHAR;
            end
         end
      end else if (err_ff == ST_OK) begin
         case (head.cls)
            CC_SKIP: begin
            end
            CC_HEX_X: begin
               upd_err = (dc_ff == '0 && lz_ff) ? ST_HEX : ST_BAD_CHAR;
            end
            CC_BIN_B: begin
               upd_err = ST_BIN;
            end
            CC_POINT: begin
               if (point_ff) begin
                  upd_err = ST_BAD_CHAR;
               end else if (!is_real) begin
                  upd_err = ST_POINT_INT;
               end else begin
                  upd_point = 1'b1;
                  upd_unit  = dc_ff;
               end
            end
            CC_MINUS: begin
               if (neg_ff || dc_ff != '0) begin
                  upd_err = ST_BAD_CHAR;
               end else if (is_uns) begin
                  upd_err = ST_MINUS_UNS;
               end else begin
                  upd_neg = 1'b1;
               end
            end
            CC_ZERO, CC_DIGIT: begin
               // A zero before any digit and before the point is only noted.
               if (head.cls == CC_ZERO && dc_ff == '0 && !point_ff) begin
                  upd_lz = 1'b1;
               end else if (dc_ff >= MAX_DC) begin
                  upd_err = ST_TOO_LONG;
               end else begin
                  upd_acc = (acc_ff << 3) + (acc_ff << 1) + ACC_W'(head.digit);
                  upd_dc  = dc_ff + DC_W'(1);
               end
            end
            default: begin
               upd_err = ST_BAD_CHAR;
            end
         endcase
      end
   end

   always_comb begin
      err_in    = err_ff;
      dc_in     = dc_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      point_in  = point_ff;
      lz_in     = lz_ff;
      unit_in   = unit_ff;
      first_in  = first_ff;
      blatch_in = blatch_ff;
      if (line_done) begin
         err_in    = ST_OK;
         dc_in     = '0;
         acc_in    = '0;
         neg_in    = 1'b0;
         point_in  = 1'b0;
         lz_in     = 1'b0;
         unit_in   = '0;
         first_in  = 1'b1;
         blatch_in = 1'b0;
      end else if (pop) begin
         err_in    = upd_err;
         dc_in     = upd_dc;
         acc_in    = upd_acc;
         neg_in    = upd_neg;
         point_in  = upd_point;
         lz_in     = upd_lz;
         unit_in   = upd_unit;
         first_in  = upd_first;
         blatch_in = upd_blatch;
      end
   end

   always_comb begin
      fin_in        = fin_ff;
      fin_valid_in  = fin_valid_ff;
      if (line_done) begin
         fin_in.vtype  = head.vtype;
         fin_in.err    = upd_err;
         fin_in.acc    = upd_acc;
         fin_in.neg    = upd_neg;
         fin_in.point  = upd_point;
         fin_in.dc     = upd_dc;
         fin_in.unit   = upd_unit;
         fin_in.blatch = upd_blatch;
         fin_valid_in  = 1'b1;
      end else if (fin_adv) begin
         fin_valid_in  = 1'b0;
      end
   end

   // Range check on the magnitude and sign; the real type takes any value.
   always_comb begin
      case (fin_ff.vtype)
         VT_U8:   range_ok = (!fin_ff.neg || fin_ff.acc == '0) && (fin_ff.acc <= U8_MAX);
         VT_U16:  range_ok = (!fin_ff.neg || fin_ff.acc == '0) && (fin_ff.acc <= U16_MAX);
         VT_U32:  range_ok = (!fin_ff.neg || fin_ff.acc == '0) && (fin_ff.acc <= U32_MAX);
         VT_I8:   range_ok = fin_ff.neg ? (fin_ff.acc <= I8_NEG) : (fin_ff.acc <= I8_POS);
         VT_I16:  range_ok = fin_ff.neg ? (fin_ff.acc <= I16_NEG) : (fin_ff.acc <= I16_POS);
         VT_I32:  range_ok = fin_ff.neg ? (fin_ff.acc <= I32_NEG) : (fin_ff.acc <= I32_POS);
         default: range_ok = 1'b1;
      endcase
   end

   always_comb begin
      status_in    = status_ff;
      value_in     = value_ff;
      frac_in      = frac_ff;
      bres_in      = bres_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fin_adv) begin
         rsp_valid_in = 1'b1;
         status_in    = fin_ff.err;
         value_in     = '0;
         frac_in      = '0;
         bres_in      = 1'b0;
         if (fin_ff.err == ST_OK) begin
            if (fin_ff.vtype == VT_BOOL) begin
               bres_in = fin_ff.blatch;
            end else if (!range_ok) begin
               status_in = ST_RANGE;
            end else begin
               value_in = fin_ff.neg ? -{1'b0, fin_ff.acc} : {1'b0, fin_ff.acc};
               if (fin_ff.vtype == VT_REAL && fin_ff.point) begin
                  frac_in = FRAC_W'(fin_ff.dc - fin_ff.unit);
               end
            end
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff       <= ST_OK;
         dc_ff        <= '0;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         point_ff     <= 1'b0;
         lz_ff        <= 1'b0;
         unit_ff      <= '0;
         first_ff     <= 1'b1;
         blatch_ff    <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         err_ff       <= err_in;
         dc_ff        <= dc_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         point_ff     <= point_in;
         lz_ff        <= lz_in;
         unit_ff      <= unit_in;
         first_ff     <= first_in;
         blatch_ff    <= blatch_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff    <= fin_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      frac_ff   <= frac_in;
      bres_ff   <= bres_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = status_ff;
   assign rsp.number_value    = value_ff;
   assign rsp.fraction_digits = frac_ff;
   assign rsp.bool_result     = bres_ff;

   `DTNP_ASSERT_NEXT(a_line_clears, clock, reset, line_done, dc_ff == '0 && first_ff && err_ff == ST_OK, "line state not cleared after line end")
   `DTNP_ASSERT_NOW(a_err_payload_zero, clock, reset, rsp_valid_ff && status_ff != ST_OK, value_ff == '0 && frac_ff == '0 && !bres_ff, "error result carries a value")
   `DTNP_ASSERT_NOW(a_digit_bound, clock, reset, 1'b1, dc_ff <= MAX_DC && unit_ff <= dc_ff, "digit count out of bounds")

endmodule

@@ src/decimal_text_number_parser.sv @@
// A line's last character passes the queue, the finished-line register and the result
// register before the result is valid. One character per cycle while the queue has
// room; the front classifies, the back end applies one queued character per cycle (a
// shift-add multiply by ten) unless the result side stalls, and the result stage holds
// one line. Reset (synchronous, active high) clears the queue, the line state and the
// result register; value_type returns to u8. The queue lets the front take characters
// while a finished result waits. Top level: configuration register, front end, back
// end. Depends on dtnp_pkg, dtnp_req_if, dtnp_rsp_if, dtnp_front and dtnp_back.
module decimal_text_number_parser import dtnp_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   dtnp_req_if.sink              req_chan,
   dtnp_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   vtype_type value_type_ff, value_type_in;
   entry_type head;
   logic      head_valid;
   logic      pop;
   logic      csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_VALUE_TYPE);
   assign csr_prdata = csr_hit ? CSR_DATA_W'(value_type_ff) : '0;

   always_comb begin
      value_type_in = value_type_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         value_type_in = vtype_type'(csr_pwdata[TYPE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_type_ff <= VALUE_TYPE_RESET;
      end else begin
         value_type_ff <= value_type_in;
      end
   end

   dtnp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .value_type (value_type_ff),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop)
   );

   dtnp_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

@@ sim/dtnp_result_check.sv @@
// Result checker for the decimal text number parser: watches the character,
// result and register ports, predicts each line's result and compares it.
// Depends on dtnp_pkg, dtnp_req_if and dtnp_rsp_if.
`timescale 1ns / 100ps

module dtnp_result_check import dtnp_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   dtnp_req_if                   req_mon,
   dtnp_rsp_if                   rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    mismatch_count,
   output int                    open_lines
);

   typedef struct packed {
      status_type        status;
      logic [VAL_W-1:0]  value;
      logic [FRAC_W-1:0] frac;
      logic              truth;
   } line_result_type;

   vtype_type        target_type;
   status_type       line_error;
   int               line_digits;
   int               line_unit_pos;
   logic [ACC_W-1:0] line_acc;
   logic             line_neg;
   logic             line_point;
   logic             line_lead_zero;
   logic             line_first;
   logic             line_truth;
   line_result_type  expected_lines[$];
   int               errors_seen;

   task automatic clear_line();
      line_error     = ST_OK;
      line_digits    = 0;
      line_unit_pos  = 0;
      line_acc       = '0;
      line_neg       = 1'b0;
      line_point     = 1'b0;
      line_lead_zero = 1'b0;
      line_first     = 1'b1;
      line_truth     = 1'b0;
   endtask

   // Applies one character to the line state; at the end of a line the
   // predicted result is queued and the line state starts over.
   task automatic parse_char(input logic [7:0] c, input logic last);
      logic            is_real;
      logic            is_uns;
      longint          sv;
      longint          lo;
      longint          hi;
      line_result_type r;
      is_real = (target_type == VT_REAL);
      is_uns  = (target_type inside {VT_U8, VT_U16, VT_U32});
      if (target_type == VT_BOOL) begin
         if (line_first) begin
            line_first = 1'b0;
            if (c == "0" || c == "f" || c == "F") begin
               line_truth = 1'b0;
            end else if (c == "1" || c == "t" || c == "T") begin
               line_truth = 1'b1;
            end else begin
               line_error = ST_BAD_CHAR;
            end
         end
      end else begin
         line_first = 1'b0;
         if (line_error == ST_OK) begin
            if (c == " " || c == "'") begin
               // Separators are skipped.
            end else if (c == "0" && line_digits == 0 && !line_point) begin
               line_lead_zero = 1'b1;
            end else if (c == "x" && line_digits == 0) begin
               line_error = line_lead_zero ? ST_HEX : ST_BAD_CHAR;
            end else if (c == "B") begin
               line_error = ST_BIN;
            end else if ((c == "." || c == ",") && !line_point) begin
               if (!is_real) begin
                  line_error = ST_POINT_INT;
               end else begin
                  line_point    = 1'b1;
                  line_unit_pos = line_digits;
               end
            end else if (c == "-" && !line_neg && line_digits == 0) begin
               if (is_uns) begin
                  line_error = ST_MINUS_UNS;
               end else begin
                  line_neg = 1'b1;
               end
            end else if (c >= "0" && c <= "9") begin
               if (line_digits >= MAX_DIGITS) begin
                  line_error = ST_TOO_LONG;
               end else begin
                  line_acc    = line_acc * 10 + (c - "0");
                  line_digits = line_digits + 1;
               end
            end else begin
               line_error = ST_BAD_CHAR;
            end
         end
      end

      if (last) begin
         r        = '0;
         r.status = line_error;
         if (line_error == ST_OK) begin
            if (target_type == VT_BOOL) begin
               r.truth = line_truth;
            end else begin
               sv = longint'(line_acc);
               if (line_neg) sv = -sv;
               case (target_type)
                  VT_U8: begin
                     lo = 0;
                     hi = longint'(U8_MAX);
                  end
                  VT_U16: begin
                     lo = 0;
                     hi = longint'(U16_MAX);
                  end
                  VT_U32: begin
                     lo = 0;
                     hi = longint'(U32_MAX);
                  end
                  VT_I8: begin
                     lo = -longint'(I8_NEG);
                     hi = longint'(I8_POS);
                  end
                  VT_I16: begin
                     lo = -longint'(I16_NEG);
                     hi = longint'(I16_POS);
                  end
                  VT_I32: begin
                     lo = -longint'(I32_NEG);
                     hi = longint'(I32_POS);
                  end
                  default: begin
                     hi = longint'({ACC_W{1'b1}});
                     lo = -hi;
                  end
               endcase
               if (sv < lo || sv > hi) begin
                  r.status = ST_RANGE;
               end else begin
                  r.value = sv[VAL_W-1:0];
                  if (is_real && line_point) r.frac = FRAC_W'(line_digits - line_unit_pos);
               end
            end
         end
         expected_lines.push_back(r);
         clear_line();
      end
   endtask

   always @(posedge clock) begin
      line_result_type got;
      line_result_type want;
      if (reset) begin
         target_type = VALUE_TYPE_RESET;
         clear_line();
         expected_lines.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_VALUE_TYPE) begin
            target_type = vtype_type'(csr_pwdata[TYPE_W-1:0]);
         end
         if (req_mon.valid && req_mon.ready) begin
            parse_char(req_mon.char_code, req_mon.line_end);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{status_type'(rsp_mon.status), rsp_mon.number_value,
                    rsp_mon.fraction_digits, rsp_mon.bool_result};
            if (expected_lines.size() == 0) begin
               if (errors_seen < 10) begin
                  $display("%0t: result with no line pending: status %s value %0d frac %0d truth %b",
                           $realtime, got.status.name(), $signed(got.value), got.frac, got.truth);
               end
               errors_seen++;
            end else begin
               want = expected_lines.pop_front();
               if (got !== want) begin
                  if (errors_seen < 10) begin
                     $display("%0t: line result mismatch: expected status %s value %0d frac %0d truth %b, got status %s value %0d frac %0d truth %b",
                              $realtime, want.status.name(), $signed(want.value), want.frac,
                              want.truth, got.status.name(), $signed(got.value), got.frac,
                              got.truth);
                  end
                  errors_seen++;
               end
            end
         end
      end
      mismatch_count <= errors_seen;
      open_lines     <= expected_lines.size();
   end

endmodule

@@ sim/decimal_text_number_parser_tb.sv @@
// Testbench top for the decimal text number parser: clock, reset, character
// stimulus, result back-pressure, register writes and the final verdict.
// Depends on dtnp_pkg, the channel interfaces, the block and dtnp_result_check.
`timescale 1ns / 100ps

module decimal_text_number_parser_tb import dtnp_pkg::*; ();

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_CHARS = 220;
   localparam longint EDGE_VALUES[14] = '{
      0, 127, 128, 255, 256, 32767, 32768, 65535, 65536, 64'd2147483647,
      64'd2147483648, 64'd4294967295, 64'd4294967296, 64'd9999999999
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          stall_seq = 0;
   int          mismatches;
   int          open_lines;
   logic [7:0]  line_buf[$];

   dtnp_req_if req_chan ();
   dtnp_rsp_if rsp_chan ();

   decimal_text_number_parser uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dtnp_result_check #(.MAX_DIGITS(MAX_DIGITS_DEFAULT)) line_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatches),
      .open_lines     (open_lines)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= c;
      req_chan.line_end  <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // Waits until every pending line result is out, then lets any trailing
   // characters without a line end work through the block.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (open_lines != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_type(input vtype_type ty);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {CSR_VALUE_TYPE, 2'b00};
      // Upper data bits are random; only the low bits select the type.
      csr_pwdata  <= ($urandom() & ~32'h7) | CSR_DATA_W'(ty);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Fills line_buf with one line: a truth character for bool; otherwise mostly well-formed
   // numbers, some near the type limits, with random decoration, the rest random noise.
   function automatic void build_line(input vtype_type ty);
      string  palette;
      string  txt;
      longint mag;
      int     cut;
      logic   is_uns;
      palette = "0x-.,B 5'";
      is_uns  = (ty inside {VT_U8, VT_U16, VT_U32});
      line_buf.delete();
      if (ty == VT_BOOL) begin
         case ($urandom_range(6))
            0: line_buf.push_back("0");
            1: line_buf.push_back("1");
            2: line_buf.push_back("f");
            3: line_buf.push_back("F");
            4: line_buf.push_back("t");
            5: line_buf.push_back("T");
            default: line_buf.push_back(8'($urandom_range(255)));
         endcase
         repeat ($urandom_range(2)) line_buf.push_back(8'($urandom_range(255)));
      end else if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(1) == 0) begin
               line_buf.push_back(8'($urandom_range(255)));
            end else begin
               line_buf.push_back(palette[$urandom_range(palette.len() - 1)]);
            end
         end
      end else begin
         case ($urandom_range(5))
            0, 1: mag = $urandom_range(999);
            2, 3: begin
               mag = EDGE_VALUES[$urandom_range(13)] + longint'($urandom_range(2)) - 1;
               if (mag < 0) mag = 0;
            end
            4: mag = {$urandom(), $urandom()} % 64'd99999999999;
            default: mag = $urandom_range(99999);
         endcase
         txt = $sformatf("%0d", mag);
         cut = -1;
         if ((ty == VT_REAL && $urandom_range(9) < 7) || $urandom_range(19) == 0) begin
            cut = $urandom_range(txt.len());
         end
         if ($urandom_range(4) == 0) line_buf.push_back(" ");
         if ($urandom_range(99) < (is_uns ? 10 : 40)) line_buf.push_back("-");
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) line_buf.push_back("0");
         end
         for (int i = 0; i < txt.len(); i++) begin
            if (i == cut) line_buf.push_back($urandom_range(1) ? "." : ",");
            line_buf.push_back(txt[i]);
            if ($urandom_range(11) == 0) line_buf.push_back("'");
         end
         if (cut == txt.len()) line_buf.push_back(".");
         if ($urandom_range(14) == 0) line_buf.push_back(8'($urandom_range(255)));
      end
   endfunction

   // Receiver: random ready, plus a long hold-off whenever one is requested.
   initial begin
      int stall_seen;
      int hold_left;
      stall_seen = 0;
      hold_left  = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_seen != stall_seq) begin
            stall_seen = stall_seq;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_psel && csr_penable)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      vtype_type seg_type;
      int        phase_chars;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.char_code <= '0;
      req_chan.line_end  <= 1'b0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines in the reset type (u8): range, minus, hex and binary
      // prefixes, stray x, point, extreme codes and an empty number.
      send_text("256");
      send_text("-");
      send_text("0x");
      send_text("B");
      send_text("x");
      send_text(".");
      send_char(8'hFF, 1'b1);
      send_char(8'h00, 1'b1);
      send_text(" ");
      wait_idle();
      write_type(VT_REAL);
      send_text("-0.05");
      send_text("1.,");
      // The type changes in the middle of a line; the minus stays taken.
      send_char("-", 1'b0);
      wait_idle();
      write_type(VT_I8);
      send_text("5");
      wait_idle();
      write_type(VT_BOOL);
      send_text("T");

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 67 : 0;
         recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 28 : 0;
         if (ph == 2) begin
            // Hold the result side while short lines keep arriving.
            wait_idle();
            write_type(VT_U16);
            stall_seq++;
            repeat (24) send_char(8'("0" + $urandom_range(9)), 1'b1);
         end
         phase_chars = 0;
         while (phase_chars < PHASE_CHARS) begin
            wait_idle();
            seg_type = vtype_type'($urandom_range(7));
            write_type(seg_type);
            repeat ($urandom_range(3, 8)) begin
               build_line(seg_type);
               phase_chars += line_buf.size();
               foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
            end
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/dtnp_pkg.sv
src/dtnp_req_if.sv
src/dtnp_rsp_if.sv
src/dtnp_front.sv
src/dtnp_back.sv
src/decimal_text_number_parser.sv
sim/dtnp_result_check.sv
sim/decimal_text_number_parser_tb.sv
